// ===== rtl/s2cd_pkg.sv =====
// ----------------------------------------------------------------------------
// s2cd_pkg
// Shared types, constants and helpers of the seconds to calendar date core.
// ----------------------------------------------------------------------------
package s2cd_pkg;

	localparam int unsigned TS_W   = 32;
	localparam int unsigned ZONE_W = 7;

	localparam logic [ZONE_W-1:0] ZONE_RESET      = 7'd22;
	localparam logic [9:0]        SEC_PER_QUARTER = 10'd900;

	// 86400 = 675 * 2^7: divide the upper 25 bits by 675, low 7 bits pass
	localparam int unsigned DAY_LO_W = 7;
	localparam int unsigned DAY_HI_W = 25;
	localparam int unsigned DAYS_W   = 16;
	// floor(x / 675) = (x * DAY_RECIP) >> 35 for x < 2^25
	localparam logic [25:0] DAY_RECIP   = 26'd50903317;
	localparam logic [9:0]  DAY_DIVISOR = 10'd675;

	// floor(t / 3600) = (t * HOUR_RECIP) >> 29 for t < 86400
	localparam int unsigned CLK_W        = 17;
	localparam logic [17:0] HOUR_RECIP   = 18'd149131;
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;

	// floor(r / 60) = (r * MIN_RECIP) >> 18 for r < 3600
	localparam int unsigned HREM_W      = 12;
	localparam logic [12:0] MIN_RECIP   = 13'd4370;
	localparam logic [5:0]  SEC_PER_MIN = 6'd60;

	localparam logic [2:0] DIV_LAST_STEP = 3'd5;

	localparam logic [10:0] BASE_YEAR  = 11'd1900;
	localparam logic [7:0]  YEAR_SPAN  = 8'd136;
	localparam logic [8:0]  DAYS_COMMON = 9'd365;
	localparam logic [8:0]  DAYS_LEAP   = 9'd366;
	localparam logic [2:0]  WD_EPOCH    = 3'd1;   // 1900-01-01 was a Monday

	localparam logic [3:0] MON_FEB = 4'd1;
	localparam logic [3:0] MON_JUL = 4'd6;
	localparam logic [3:0] MON_DEC = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_YEAR,
		ST_MONTH,
		ST_FIN
	} back_state_t;

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
		logic [3:0] m;
		m = (mon > MON_JUL) ? mon - 4'd1 : mon;
		if (mon == MON_FEB)
			return 5'd28 + {4'd0, leap};
		return m[0] ? 5'd30 : 5'd31;
	endfunction

	// value mod 7 for value < 49
	function automatic logic [2:0] mod7(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		if (r >= 6'd28) r = r - 6'd28;
		if (r >= 6'd14) r = r - 6'd14;
		if (r >= 6'd7)  r = r - 6'd7;
		return r[2:0];
	endfunction

endpackage

// ===== rtl/s2cd_ts_if.sv =====
// ----------------------------------------------------------------------------
// s2cd_ts_if
// Valid/ready channel carrying one 32-bit seconds count per beat.
// ----------------------------------------------------------------------------
interface s2cd_ts_if;
	logic        valid;
	logic        ready;
	logic [31:0] timestamp_seconds;

	modport source(output valid, output timestamp_seconds, input ready);
	modport sink(input valid, input timestamp_seconds, output ready);
endinterface

// ===== rtl/s2cd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// s2cd_cfg_if
// Write channel for the time-zone offset register.
// ----------------------------------------------------------------------------
interface s2cd_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] zone_quarter_hours;

	modport source(output valid, output zone_quarter_hours, input ready);
	modport sink(input valid, input zone_quarter_hours, output ready);
endinterface

// ===== rtl/s2cd_date_if.sv =====
// ----------------------------------------------------------------------------
// s2cd_date_if
// Valid/ready channel carrying one calendar date and time of day per beat.
// ----------------------------------------------------------------------------
interface s2cd_date_if;
	logic        valid;
	logic        ready;
	logic [10:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [2:0]  weekday;

	modport source(output valid, output year, output month, output day, output hour,
		output minute, output second, output weekday, input ready);
	modport sink(input valid, input year, input month, input day, input hour,
		input minute, input second, input weekday, output ready);
endinterface

// ===== rtl/seconds_to_calendar_date_core.sv =====
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_core
// Seconds since 1900 plus zone offset to Gregorian date, time and weekday.
// ----------------------------------------------------------------------------
// channel | modport | beat
// cfg     | sink    | zone_quarter_hours, offset in 15 minute units
// stamp   | sink    | timestamp_seconds, seconds since 1900-01-01
// date    | source  | year, month, day, hour, minute, second, weekday
//
// One timestamp passes the back sequencer through division, a year loop over Y the
// years past 1900 (up to 136), a month loop over M the month index (up to 11), and finish.
// The result register loads in the finish step.
// A result still waiting on the date channel holds the back in its finish step.
// The offset stage and a two-entry queue keep taking beats while the back works.
// Reset loads the zone register with 22 and empties every stage.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_core (
	input  logic        clk,
	input  logic        arst_n,
	s2cd_cfg_if.sink    cfg,
	s2cd_ts_if.sink     stamp,
	s2cd_date_if.source date
);

	s2cd_ts_if front_ts ();
	s2cd_ts_if back_ts ();

	s2cd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.stamp    (stamp),
		.local_ts (front_ts)
	);

	s2cd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_ts),
		.rd     (back_ts)
	);

	s2cd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.local_ts (back_ts),
		.date     (date)
	);

endmodule

// ===== rtl/s2cd_front.sv =====
// ----------------------------------------------------------------------------
// s2cd_front
// Holds the zone register, applies the offset and registers the local time.
// ----------------------------------------------------------------------------
module s2cd_front (
	input  logic          clk,
	input  logic          arst_n,
	s2cd_cfg_if.sink      cfg,
	s2cd_ts_if.sink       stamp,
	s2cd_ts_if.source     local_ts
);

	logic [s2cd_pkg::ZONE_W-1:0] zone_q;
	logic                        valid_s1;
	logic [s2cd_pkg::TS_W-1:0]   sum_s1;
	logic [16:0]                 offset;

	assign cfg.ready   = 1'b1;
	assign stamp.ready = !valid_s1 || local_ts.ready;
	assign offset      = {10'd0, zone_q} * {7'd0, s2cd_pkg::SEC_PER_QUARTER};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= s2cd_pkg::ZONE_RESET;
		end else if (cfg.valid) begin
			zone_q <= cfg.zone_quarter_hours;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stamp.ready) begin
			valid_s1 <= stamp.valid;
		end
	end

	// wraps modulo 2^32
	always_ff @(posedge clk) begin
		if (stamp.valid && stamp.ready) begin
			sum_s1 <= stamp.timestamp_seconds + {15'd0, offset};
		end
	end

	assign local_ts.valid             = valid_s1;
	assign local_ts.timestamp_seconds = sum_s1;

endmodule

// ===== rtl/s2cd_fifo.sv =====
// ----------------------------------------------------------------------------
// s2cd_fifo
// Two-entry queue of local times between front and back.
// ----------------------------------------------------------------------------
module s2cd_fifo (
	input  logic      clk,
	input  logic      arst_n,
	s2cd_ts_if.sink   wr,
	s2cd_ts_if.source rd
);

	logic [s2cd_pkg::TS_W-1:0] mem [2];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                count_q;
	logic                      push;
	logic                      pop;

	assign wr.ready = (count_q != 2'd2);
	assign rd.valid = (count_q != 2'd0);
	assign rd.timestamp_seconds = mem[rd_ptr_q];
	assign push = wr.valid && wr.ready;
	assign pop  = rd.valid && rd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr.timestamp_seconds;
		end
	end

endmodule

// ===== rtl/s2cd_back.sv =====
// ----------------------------------------------------------------------------
// s2cd_back
// Sequencer: day division, year and month subtraction, time of day split.
// ----------------------------------------------------------------------------
module s2cd_back (
	input  logic        clk,
	input  logic        arst_n,
	s2cd_ts_if.sink     local_ts,
	s2cd_date_if.source date
);

	s2cd_pkg::back_state_t state_q, state_d;

	logic [2:0]                      cnt_q;
	logic [s2cd_pkg::DAY_HI_W-1:0]   x_q;
	logic [s2cd_pkg::DAY_LO_W-1:0]   lo_q;
	logic [s2cd_pkg::DAYS_W-1:0]     days_q;
	logic [s2cd_pkg::CLK_W-1:0]      tod_q;
	logic [4:0]                      hour_q;
	logic [s2cd_pkg::HREM_W-1:0]     hrem_q;
	logic [5:0]                      min_q;
	logic [5:0]                      sec_q;
	logic [7:0]                      yoff_q;
	logic [3:0]                      mon_q;
	logic [2:0]                      wd_q;
	logic                            leap_q;

	logic [50:0]                     day_prod;
	logic [9:0]                      day_rem;
	logic [34:0]                     hour_prod;
	logic [s2cd_pkg::HREM_W-1:0]     hour_rem;
	logic [24:0]                     min_prod;
	logic [5:0]                      sec_rem;

	logic       leap;
	logic [8:0] diy;
	logic       yr_ge;
	logic [4:0] dim;
	logic       mo_ge;

	logic       ovalid_q;
	logic       ld_out;

	// remainders are below 2^n, so n-bit wrapping arithmetic is exact
	assign day_prod  = {26'd0, x_q} * {25'd0, s2cd_pkg::DAY_RECIP};
	assign day_rem   = x_q[9:0] - days_q[9:0] * s2cd_pkg::DAY_DIVISOR;
	assign hour_prod = {18'd0, tod_q} * {17'd0, s2cd_pkg::HOUR_RECIP};
	assign hour_rem  = tod_q[11:0] - {7'd0, hour_q} * s2cd_pkg::SEC_PER_HOUR;
	assign min_prod  = {13'd0, hrem_q} * {12'd0, s2cd_pkg::MIN_RECIP};
	assign sec_rem   = hrem_q[5:0] - min_q * s2cd_pkg::SEC_PER_MIN;

	// offset 0 is 1900 (not leap); 2000 is leap; range ends before 2100
	assign leap  = (yoff_q[1:0] == 2'd0) && (yoff_q != 8'd0);
	assign diy   = leap ? s2cd_pkg::DAYS_LEAP : s2cd_pkg::DAYS_COMMON;
	assign yr_ge = days_q >= {7'd0, diy};
	assign dim   = s2cd_pkg::month_len(leap_q, mon_q);
	assign mo_ge = (mon_q != s2cd_pkg::MON_DEC) && (days_q >= {11'd0, dim});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= s2cd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		ld_out         = 1'b0;
		local_ts.ready = 1'b0;
		unique case (state_q)
			s2cd_pkg::ST_IDLE: begin
				local_ts.ready = 1'b1;
				if (local_ts.valid) begin
					state_d = s2cd_pkg::ST_DIV;
				end
			end
			s2cd_pkg::ST_DIV: begin
				if (cnt_q == s2cd_pkg::DIV_LAST_STEP) begin
					state_d = s2cd_pkg::ST_YEAR;
				end
			end
			s2cd_pkg::ST_YEAR: begin
				if (!yr_ge) state_d = s2cd_pkg::ST_MONTH;
			end
			s2cd_pkg::ST_MONTH: begin
				if (!mo_ge) state_d = s2cd_pkg::ST_FIN;
			end
			s2cd_pkg::ST_FIN: begin
				if (!ovalid_q || date.ready) begin
					ld_out  = 1'b1;
					state_d = s2cd_pkg::ST_IDLE;
				end
			end
			default: state_d = s2cd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			s2cd_pkg::ST_IDLE: begin
				x_q   <= local_ts.timestamp_seconds[31:7];
				lo_q  <= local_ts.timestamp_seconds[6:0];
				cnt_q <= 3'd0;
			end
			s2cd_pkg::ST_DIV: begin
				// each register settles in the cycle after its source
				days_q <= day_prod[50:35];
				tod_q  <= {day_rem, lo_q};
				hour_q <= hour_prod[33:29];
				hrem_q <= hour_rem;
				min_q  <= min_prod[23:18];
				sec_q  <= sec_rem;
				cnt_q  <= cnt_q + 3'd1;
				yoff_q <= 8'd0;
				wd_q   <= s2cd_pkg::WD_EPOCH;
			end
			s2cd_pkg::ST_YEAR: begin
				leap_q <= leap;
				mon_q  <= 4'd0;
				if (yr_ge) begin
					days_q <= days_q - {7'd0, diy};
					yoff_q <= yoff_q + 8'd1;
					wd_q   <= s2cd_pkg::mod7({3'd0, wd_q} + (leap ? 6'd2 : 6'd1));
				end
			end
			s2cd_pkg::ST_MONTH: begin
				if (mo_ge) begin
					days_q <= days_q - {11'd0, dim};
					mon_q  <= mon_q + 4'd1;
					wd_q   <= s2cd_pkg::mod7({3'd0, wd_q} + {1'b0, dim - 5'd28});
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ld_out) begin
			ovalid_q <= 1'b1;
		end else if (date.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			date.year    <= s2cd_pkg::BASE_YEAR + {3'd0, yoff_q};
			date.month   <= mon_q + 4'd1;
			date.day     <= days_q[4:0] + 5'd1;
			date.hour    <= hour_q;
			date.minute  <= min_q;
			date.second  <= sec_q;
			date.weekday <= s2cd_pkg::mod7({3'd0, wd_q} + {1'b0, days_q[4:0]});
		end
	end

	assign date.valid = ovalid_q;

`ifndef SYNTH
	a_year_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == s2cd_pkg::ST_YEAR |-> yoff_q <= s2cd_pkg::YEAR_SPAN)
		else $error("year offset beyond range");
	a_div_to_year: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == s2cd_pkg::ST_DIV && cnt_q == s2cd_pkg::DIV_LAST_STEP)
		|=> state_q == s2cd_pkg::ST_YEAR)
		else $error("day division did not hand over");
	a_fin_day: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == s2cd_pkg::ST_FIN |-> days_q < 16'd31 && mon_q <= s2cd_pkg::MON_DEC)
		else $error("day of month out of range at finish");
	a_fin_time: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == s2cd_pkg::ST_FIN |-> hour_q < 5'd24 && min_q < 6'd60 && sec_q < 6'd60)
		else $error("time of day out of range at finish");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q == s2cd_pkg::ST_FIN))
		else $error("result raised outside finish");
`endif

endmodule
